[rtl/sbdc_pkg.sv]
`timescale 1ns / 1ps

package sbdc_pkg;

    // Default number of stored values per set.
    localparam int CAPACITY = 64;

    // Digit counts run from 1 to 10; one list per count.
    localparam int NUM_KEYS   = 10;
    localparam int KEY_W      = 4;
    localparam int VALUE_W    = 32;
    localparam int QUEUE_DEPTH = 2;

    // Smallest magnitude with two, three, ... ten digits.
    localparam logic [VALUE_W-1:0] DIGIT_THRESH [NUM_KEYS-1] = '{
        32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    // One classified item travelling from the front to the back.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [KEY_W-1:0]   key;
        logic               last;
    } item_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PICK,
        ST_READ,
        ST_SHOW
    } back_state_t;

    // Decimal digit count of the magnitude of a two's complement value.
    function automatic logic [KEY_W-1:0] digit_count(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [KEY_W-1:0]   d;
        mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
        d = KEY_W'(1);
        for (int i = 0; i < NUM_KEYS - 1; i++) begin
            if (mag >= DIGIT_THRESH[i]) begin
                d = KEY_W'(i + 2);
            end
        end
        return d;
    endfunction

    // Index of the lowest set bit of a list mask.
    function automatic logic [KEY_W-1:0] lowest_key(input logic [NUM_KEYS-1:0] m);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = KEY_W'(i);
            end
        end
        return r;
    endfunction

endpackage

[rtl/stable_sort_by_decimal_digit_count_core.sv]
`timescale 1ns / 1ps

// Collects signed 32-bit values, one item per cycle while the back end is loading,
// until an item with s_last_in high arrives, then returns every stored value ordered
// by the decimal digit count of its magnitude, with equal counts kept in arrival
// order; m_last_out marks the final result and m_dropped reports on every result of
// the set that items beyond CAPACITY were discarded. A front stage computes the
// digit count and passes the item through a two-entry queue to the back end, which
// appends it to one of ten linked lists held in memory. After the last item the back
// end chooses a list, then walks the lists one result at a time, reading each result
// from the value and link memories and then waiting until the output register is
// free, its pace bounded by the registered read of the link memory; it chooses again
// each time it moves to the next non-empty list. While a set drains the next set's
// first items wait in the front stage and the queue.

module stable_sort_by_decimal_digit_count_core #(
    parameter int CAPACITY = sbdc_pkg::CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sbdc_pkg::VALUE_W-1:0] s_value,
    input  logic                                s_last_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sbdc_pkg::VALUE_W-1:0] m_sorted_value,
    output logic                                m_last_out,
    output logic                                m_dropped
);

    logic            push;
    sbdc_pkg::item_t push_item;
    logic            q_full;
    logic            q_valid;
    logic            pop;
    sbdc_pkg::item_t pop_item;
    logic [sbdc_pkg::VALUE_W-1:0] out_value;

    // Front: stage and classify each item.
    sbdc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .in_last   (s_last_in),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    // Queue between the front and the back.
    sbdc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    // Back: store, link and drain in digit-count order.
    sbdc_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (pop_item),
        .pop         (pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_value   (out_value),
        .out_last    (m_last_out),
        .out_dropped (m_dropped)
    );

    assign m_sorted_value = signed'(out_value);

endmodule

[rtl/sbdc_ram.sv]
`timescale 1ns / 1ps

module sbdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port that holds when not enabled.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sbdc_front.sv]
`timescale 1ns / 1ps

module sbdc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sbdc_pkg::VALUE_W-1:0]        in_value,
    input  logic                                in_last,
    output logic                                push,
    output sbdc_pkg::item_t                     push_item,
    input  logic                                q_full
);

    logic                              valid_reg;
    logic                              valid_next;
    logic [sbdc_pkg::VALUE_W-1:0]      value_reg;
    logic                              last_reg;

    // The stage hands its item on whenever the queue has room.
    assign push     = valid_reg && !q_full;
    assign in_ready = !valid_reg || push;

    // Classify the staged value by its digit count.
    always_comb begin
        push_item.value = value_reg;
        push_item.key   = sbdc_pkg::digit_count(value_reg);
        push_item.last  = last_reg;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            value_reg <= in_value;
            last_reg  <= in_last;
        end
    end

endmodule

[rtl/sbdc_fifo.sv]
`timescale 1ns / 1ps

module sbdc_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sbdc_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output sbdc_pkg::item_t pop_item
);

    localparam int PW = $clog2(sbdc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(sbdc_pkg::QUEUE_DEPTH + 1);

    sbdc_pkg::item_t entry_reg [sbdc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   wptr_next;
    logic [PW-1:0]   rptr_reg;
    logic [PW-1:0]   rptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full      = (count_reg == CW'(sbdc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rptr_reg];

    // Pointer wrap and occupancy.
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PW'(sbdc_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == PW'(sbdc_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

[rtl/sbdc_back.sv]
`timescale 1ns / 1ps

module sbdc_back #(
    parameter int CAPACITY = sbdc_pkg::CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  sbdc_pkg::item_t                     q_item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sbdc_pkg::VALUE_W-1:0]        out_value,
    output logic                                out_last,
    output logic                                out_dropped
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int NK = sbdc_pkg::NUM_KEYS;
    localparam int KW = sbdc_pkg::KEY_W;
    localparam int VW = sbdc_pkg::VALUE_W;

    sbdc_pkg::back_state_t state_reg;
    sbdc_pkg::back_state_t state_next;

    logic [FW-1:0]  fill_reg;
    logic           overflow_reg;
    logic [NK-1:0]  nonempty_reg;
    logic [NK-1:0]  remain_reg;
    logic [AW-1:0]  head_reg [NK];
    logic [AW-1:0]  tail_reg [NK];
    logic [KW-1:0]  key_reg;
    logic [AW-1:0]  ptr_reg;
    logic           out_valid_reg;
    logic [VW-1:0]  out_value_reg;
    logic           out_last_reg;
    logic           out_dropped_reg;

    logic [KW-1:0]  kidx;
    logic           room;
    logic           store;
    logic           rd_en;
    logic           out_free;
    logic           out_load;
    logic           fin_list;
    logic [NK-1:0]  remain_after;
    logic           final_item;
    logic [KW-1:0]  next_key;
    logic [VW-1:0]  value_rdata;
    logic [AW-1:0]  link_rdata;

    // Value storage in arrival order.
    sbdc_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (store),
        .waddr (fill_reg[AW-1:0]),
        .wdata (q_item.value),
        .re    (rd_en),
        .raddr (ptr_reg),
        .rdata (value_rdata)
    );

    // Forward links: each entry points to the next entry with the same digit count.
    sbdc_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (store && nonempty_reg[kidx]),
        .waddr (tail_reg[kidx]),
        .wdata (fill_reg[AW-1:0]),
        .re    (rd_en),
        .raddr (ptr_reg),
        .rdata (link_rdata)
    );

    // Item decode and drain bookkeeping.
    always_comb begin
        kidx         = q_item.key - KW'(1);
        room         = (fill_reg < FW'(CAPACITY));
        out_free     = !out_valid_reg || out_ready;
        fin_list     = (ptr_reg == tail_reg[key_reg]);
        remain_after = remain_reg & ~(NK'(1) << key_reg);
        final_item   = fin_list && (remain_after == '0);
        next_key     = sbdc_pkg::lowest_key(remain_reg);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbdc_pkg::ST_LOAD: begin
                if (q_valid && q_item.last) begin
                    state_next = sbdc_pkg::ST_PICK;
                end
            end
            sbdc_pkg::ST_PICK: begin
                state_next = sbdc_pkg::ST_READ;
            end
            sbdc_pkg::ST_READ: begin
                state_next = sbdc_pkg::ST_SHOW;
            end
            sbdc_pkg::ST_SHOW: begin
                if (out_free) begin
                    if (final_item) begin
                        state_next = sbdc_pkg::ST_LOAD;
                    end else if (fin_list) begin
                        state_next = sbdc_pkg::ST_PICK;
                    end else begin
                        state_next = sbdc_pkg::ST_READ;
                    end
                end
            end
            default: state_next = sbdc_pkg::ST_LOAD;
        endcase
    end

    // State outputs.
    always_comb begin
        pop      = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            sbdc_pkg::ST_LOAD: pop      = q_valid;
            sbdc_pkg::ST_PICK: ;
            sbdc_pkg::ST_READ: rd_en    = 1'b1;
            sbdc_pkg::ST_SHOW: out_load = out_free;
            default: ;
        endcase
        store = pop && room;
    end

    // Control state: fill level, list flags and the output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sbdc_pkg::ST_LOAD;
            fill_reg      <= '0;
            overflow_reg  <= 1'b0;
            nonempty_reg  <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (store) begin
                fill_reg           <= fill_reg + FW'(1);
                nonempty_reg[kidx] <= 1'b1;
            end else if (pop) begin
                overflow_reg <= 1'b1;
            end
            if (pop && q_item.last) begin
                remain_reg <= nonempty_reg | (store ? (NK'(1) << kidx) : '0);
            end else if (out_load && fin_list) begin
                remain_reg <= remain_after;
            end
            if (out_load && final_item) begin
                fill_reg     <= '0;
                overflow_reg <= 1'b0;
                nonempty_reg <= '0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // List heads, tails, walk pointer and the output payload.
    always_ff @(posedge aclk) begin
        if (store) begin
            tail_reg[kidx] <= fill_reg[AW-1:0];
            if (!nonempty_reg[kidx]) begin
                head_reg[kidx] <= fill_reg[AW-1:0];
            end
        end
        if (state_reg == sbdc_pkg::ST_PICK) begin
            key_reg <= next_key;
            ptr_reg <= head_reg[next_key];
        end else if (out_load && !fin_list) begin
            ptr_reg <= link_rdata;
        end
        if (out_load) begin
            out_value_reg   <= value_rdata;
            out_last_reg    <= final_item;
            out_dropped_reg <= overflow_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_last    = out_last_reg;
    assign out_dropped = out_dropped_reg;

endmodule

[tb/sv/sort_order_checker.sv]
`timescale 1ns / 1ps

module sort_order_checker #(
    parameter int CAPACITY = sbdc_pkg::CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [sbdc_pkg::VALUE_W-1:0] s_value,
    input  logic                                s_last_in,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [sbdc_pkg::VALUE_W-1:0] m_sorted_value,
    input  logic                                m_last_out,
    input  logic                                m_dropped,
    output int                                  mismatch_count,
    output int                                  results_pending
);

    localparam int MAX_DIGITS = 10;

    typedef struct packed {
        logic signed [sbdc_pkg::VALUE_W-1:0] value;
        logic                                last;
        logic                                dropped;
    } sorted_item_t;

    // Shadow copy of the block's buffer for the set being collected.
    logic signed [sbdc_pkg::VALUE_W-1:0] held_values [CAPACITY];
    int                                  held_digits [CAPACITY];
    int                                  fill_level;
    logic                                overflow_flag;

    // Results still owed by the block, oldest first.
    sorted_item_t sorted_expect[$];

    // The result seen on the output channel at this edge.
    sorted_item_t delivered;

    // Number of decimal digits in the magnitude; the most negative value has ten.
    function automatic int magnitude_digits(input logic [sbdc_pkg::VALUE_W-1:0] raw);
        logic [sbdc_pkg::VALUE_W-1:0] mag;
        int                           digits;
        mag    = raw[sbdc_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
        digits = 1;
        while (mag >= 10) begin
            mag    = mag / 10;
            digits = digits + 1;
        end
        return digits;
    endfunction

    // Store one accepted item; on the last item of a set, queue the whole set in
    // stable digit-count order and start over.
    task automatic absorb_item(input logic signed [sbdc_pkg::VALUE_W-1:0] v, input logic l);
        sorted_item_t entry;
        int           emitted;
        if (fill_level < CAPACITY) begin
            held_values[fill_level] = v;
            held_digits[fill_level] = magnitude_digits(v);
            fill_level = fill_level + 1;
        end else begin
            overflow_flag = 1'b1;
        end
        if (l) begin
            emitted = 0;
            for (int d = 1; d <= MAX_DIGITS; d++) begin
                for (int i = 0; i < fill_level; i++) begin
                    if (held_digits[i] == d) begin
                        entry.value   = held_values[i];
                        entry.last    = 1'b0;
                        entry.dropped = overflow_flag;
                        sorted_expect.push_back(entry);
                        emitted = emitted + 1;
                    end
                end
            end
            if (emitted > 0) begin
                sorted_expect[sorted_expect.size() - 1].last = 1'b1;
            end
            fill_level    = 0;
            overflow_flag = 1'b0;
        end
    endtask

    // Compare one delivered result with the oldest one owed.
    task automatic compare_result(input sorted_item_t got);
        sorted_item_t want;
        if (sorted_expect.size() == 0) begin
            if (mismatch_count < 10) begin
                $display("[%0t] unexpected item: value=%0d last=%0b dropped=%0b",
                         $realtime, got.value, got.last, got.dropped);
            end
            mismatch_count = mismatch_count + 1;
        end else begin
            want = sorted_expect.pop_front();
            if (want !== got) begin
                if (mismatch_count < 10) begin
                    $write("[%0t] mismatch: expected value=%0d last=%0b dropped=%0b,",
                           $realtime, want.value, want.last, want.dropped);
                    $display(" got value=%0d last=%0b dropped=%0b",
                             got.value, got.last, got.dropped);
                end
                mismatch_count = mismatch_count + 1;
            end
        end
    endtask

    // Sample both channels at the rising edge, before the block updates.
    always @(posedge aclk) begin
        if (!aresetn) begin
            mismatch_count = 0;
            fill_level     = 0;
            overflow_flag  = 1'b0;
            sorted_expect.delete();
        end else begin
            if (s_valid && s_ready) begin
                absorb_item(s_value, s_last_in);
            end
            if (m_valid && m_ready) begin
                delivered.value   = m_sorted_value;
                delivered.last    = m_last_out;
                delivered.dropped = m_dropped;
                compare_result(delivered);
            end
        end
        results_pending = sorted_expect.size();
    end

endmodule

[tb/sv/tb_stable_sort_by_decimal_digit_count_core.sv]
`timescale 1ns / 1ps

module tb_stable_sort_by_decimal_digit_count_core;

    localparam int CAPACITY       = sbdc_pkg::CAPACITY;
    localparam int RANDOM_ITEMS   = 150;
    localparam int CALM_FROM      = 125;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                                aclk;
    logic                                aresetn   = 1'b0;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    logic signed [sbdc_pkg::VALUE_W-1:0] s_value   = '0;
    logic                                s_last_in = 1'b0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    logic signed [sbdc_pkg::VALUE_W-1:0] m_sorted_value;
    logic                                m_last_out;
    logic                                m_dropped;

    logic s_fire     = 1'b0;
    bit   allow_idle = 1'b1;
    int   ready_hold = 0;
    int   idle_cycles = 0;
    int   mismatch_count;
    int   results_pending;

    stable_sort_by_decimal_digit_count_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last_in      (s_last_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last_out     (m_last_out),
        .m_dropped      (m_dropped)
    );

    sort_order_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_last_in       (s_last_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sorted_value  (m_sorted_value),
        .m_last_out      (m_last_out),
        .m_dropped       (m_dropped),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Remember whether an item went in at the last rising edge.
    always @(posedge aclk) begin
        s_fire <= s_valid && s_ready;
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side back-pressure: random stall bursts between ready stretches.
    always @(negedge aclk) begin
        if (!allow_idle) begin
            m_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(1, 14) - 1;
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 20);
        end
    end

    // Mostly values aimed at a chosen digit count, plus raw words and boundaries.
    function automatic logic signed [sbdc_pkg::VALUE_W-1:0] pick_value();
        longint lo;
        longint hi;
        longint mag;
        int     digits;
        int     mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            return $urandom;
        end
        if (mode == 1) begin
            case ($urandom_range(0, 5))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 0;
                3:       return -1;
                4:       return 1000000000;
                default: return -1000000000;
            endcase
        end
        digits = $urandom_range(1, 10);
        lo = 1;
        repeat (digits - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (digits == 1) begin
            lo = 0;
        end
        if (hi > 64'sd2147483647) begin
            hi = 64'sd2147483647;
        end
        mag = lo + (longint'($urandom) % (hi - lo + 1));
        return $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
    endfunction

    // Offer one item, with an optional gap first, and wait until it is taken.
    task automatic send_item(input logic signed [sbdc_pkg::VALUE_W-1:0] v, input logic l);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_value   <= v;
        s_last_in <= l;
        do @(negedge aclk); while (!s_fire);
    endtask

    initial begin
        int  sent;
        int  set_idx;
        int  set_len;
        bit  set_calm;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A set of one item.
        send_item(0, 1'b1);

        // Digit-count boundaries, both signs, the extremes, and ties in arrival order.
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(9, 1'b0);
        send_item(-10, 1'b0);
        send_item(0, 1'b0);
        send_item(-9, 1'b0);
        send_item(10, 1'b0);
        send_item(99, 1'b0);
        send_item(100, 1'b0);
        send_item(-12, 1'b0);
        send_item(-1, 1'b0);
        send_item(999999999, 1'b0);
        send_item(1000000000, 1'b0);
        send_item(-1000000000, 1'b0);
        send_item(-999999999, 1'b0);
        send_item(12, 1'b0);
        send_item(5, 1'b1);

        // Two short sets back to back, negative last.
        send_item(-7, 1'b1);
        send_item(123456, 1'b0);
        send_item(-123, 1'b1);

        // Random sets: mostly short, one that fills the buffer exactly and one
        // that overflows it so that even the last item is dropped.
        sent    = 0;
        set_idx = 0;
        while (sent < RANDOM_ITEMS || set_idx <= 5) begin
            if (set_idx == 2) begin
                set_len = CAPACITY + $urandom_range(1, 3);
            end else if (set_idx == 5) begin
                set_len = CAPACITY;
            end else begin
                set_len = $urandom_range(1, 10);
            end
            set_calm = ($urandom_range(0, 4) == 0);
            for (int j = 0; j < set_len; j++) begin
                allow_idle = !set_calm && (sent < CALM_FROM);
                send_item(pick_value(), j == set_len - 1);
                sent = sent + 1;
            end
            set_idx = set_idx + 1;
        end
        allow_idle = 1'b0;
        s_valid   <= 1'b0;

        // Let the last set drain, then give stray results a chance to show up.
        while (results_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/sbdc_pkg.sv
rtl/sbdc_ram.sv
rtl/sbdc_front.sv
rtl/sbdc_fifo.sv
rtl/sbdc_back.sv
rtl/stable_sort_by_decimal_digit_count_core.sv
tb/sv/sort_order_checker.sv
tb/sv/tb_stable_sort_by_decimal_digit_count_core.sv
